### design/kab_pkg.sv
// Shared constants and types for the binary-lifting ancestor table.
package kab_pkg;

    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;
    localparam int NODE_W     = 10;
    localparam int CMD_W      = 2;

    localparam logic [CMD_W-1:0] CMD_LINK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] node;
    } t_entry;

endpackage

### design/kth_ancestor_binary_lifting.sv
// Binary-lifting ancestor table with link, remove and query requests.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_command, i_node, i_parent, i_steps
//   result    out        o_valid / i_stall    o_ancestor
//
// The table sits in one memory of NODES*LEVELS entries, one read and one write a cycle.
// After reset a clearing pass writes every entry before the first request is taken. A link
// writes level 0, then fills each upper level by a serial chain of one table read per level
// and stops at the first level without an ancestor; a remove clears its levels in turn. A
// query is taken in idle, walks the levels from the top and resolves the last read in a final
// state; a walk that leaves the tree ends early. A held result stalls only the finish of the next
// query. Only queries give a result.
module kth_ancestor_binary_lifting
    import kab_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_parent,
    input  logic [NODE_W-1:0] i_steps,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [NODE_W-1:0] o_ancestor
);

    localparam int DEPTH = NODES * LEVELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LINK0 = 3'd2;
    localparam logic [2:0] ST_LINK  = 3'd3;
    localparam logic [2:0] ST_RMV   = 3'd4;
    localparam logic [2:0] ST_QRY   = 3'd5;
    localparam logic [2:0] ST_QEND  = 3'd6;

    function automatic logic [AW-1:0] row_of(input logic [NODE_W-1:0] x);
        row_of = AW'(32'(x) * LEVELS);
    endfunction

    function automatic logic in_range(input logic [NODE_W-1:0] x);
        in_range = (32'(x) < NODES);
    endfunction

    t_entry r_mem [DEPTH];
    t_entry r_q;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_base, n_base;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [NODE_W-1:0] r_node, n_node;
    logic [NODE_W-1:0] r_par, n_par;
    logic [LEVELS-1:0] r_steps, n_steps;
    logic [NODE_W-1:0] r_x, n_x;
    logic              r_pend, n_pend;
    logic              r_ok, n_ok;
    logic              r_fwd, n_fwd;
    t_entry            r_fwd_data, n_fwd_data;
    logic              r_ovalid, n_ovalid;
    logic [NODE_W-1:0] r_oanc, n_oanc;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    t_entry            wdata;
    t_entry            got;
    logic [NODE_W-1:0] cur_x;
    logic              cur_ok;
    logic              accept;

    assign accept     = i_valid && !o_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ovalid;
    assign o_ancestor = r_oanc;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_base     = r_base;
        n_lvl      = r_lvl;
        n_node     = r_node;
        n_par      = r_par;
        n_steps    = r_steps;
        n_x        = r_x;
        n_pend     = r_pend;
        n_ok       = r_ok;
        n_fwd      = r_fwd;
        n_fwd_data = r_fwd_data;
        n_ovalid   = r_ovalid;
        n_oanc     = r_oanc;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = r_addr;
        raddr      = '0;
        wdata      = '0;
        got        = r_fwd ? r_fwd_data : (r_ok ? r_q : t_entry'('0));
        cur_x      = r_pend ? r_q.node : r_x;
        cur_ok     = !r_pend || (r_ok && r_q.vld);

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                we     = 1'b1;
                waddr  = r_addr;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_node  = i_node;
                    n_par   = i_parent;
                    n_base  = row_of(i_node);
                    n_addr  = row_of(i_node);
                    n_steps = LEVELS'(i_steps);
                    n_x     = i_node;
                    n_pend  = 1'b0;
                    case (i_command)
                        CMD_LINK: begin
                            if (in_range(i_node)) begin
                                n_state = ST_LINK0;
                            end
                        end
                        CMD_REMOVE: begin
                            if (in_range(i_node)) begin
                                n_lvl   = '0;
                                n_state = ST_RMV;
                            end
                        end
                        CMD_QUERY: begin
                            n_lvl = LW'(LEVELS - 1);
                            // Any step bit beyond the top level cannot be climbed.
                            if ((i_steps >> LEVELS) != '0) begin
                                n_x     = '0;
                                n_state = ST_QEND;
                            end else begin
                                n_state = ST_QRY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LINK0: begin
                we    = 1'b1;
                waddr = r_base;
                wdata = '{vld: 1'b1, node: r_par};
                if (LEVELS > 1) begin
                    re         = in_range(r_par);
                    raddr      = row_of(r_par);
                    n_ok       = in_range(r_par);
                    // A node linked to itself reads back the entry written here.
                    n_fwd      = (r_par == r_node);
                    n_fwd_data = '{vld: 1'b1, node: r_par};
                    n_lvl      = LW'(1);
                    n_state    = ST_LINK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LINK: begin
                we    = 1'b1;
                waddr = r_base + AW'(r_lvl);
                wdata = got;
                if (got.vld && (r_lvl != LW'(LEVELS - 1))) begin
                    re         = in_range(got.node);
                    raddr      = row_of(got.node) + AW'(r_lvl);
                    n_ok       = in_range(got.node);
                    n_fwd      = (got.node == r_node);
                    n_fwd_data = got;
                    n_lvl      = r_lvl + LW'(1);
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RMV: begin
                we     = 1'b1;
                waddr  = r_addr;
                n_addr = r_addr + AW'(1);
                n_lvl  = r_lvl + LW'(1);
                if (r_lvl == LW'(LEVELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRY: begin
                if (!cur_ok) begin
                    n_x     = '0;
                    n_pend  = 1'b0;
                    n_state = ST_QEND;
                end else begin
                    n_x = cur_x;
                    if (r_steps[r_lvl]) begin
                        re     = in_range(cur_x);
                        raddr  = row_of(cur_x) + AW'(r_lvl);
                        n_ok   = in_range(cur_x);
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (r_lvl == '0) begin
                        n_state = ST_QEND;
                    end else begin
                        n_lvl = r_lvl - LW'(1);
                    end
                end
            end
            ST_QEND: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oanc   = cur_ok ? cur_x : '0;
                    n_pend   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_q <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_addr   <= '0;
            r_lvl    <= '0;
            r_pend   <= 1'b0;
            r_ok     <= 1'b0;
            r_fwd    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_lvl    <= n_lvl;
            r_pend   <= n_pend;
            r_ok     <= n_ok;
            r_fwd    <= n_fwd;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_node     <= n_node;
        r_par      <= n_par;
        r_steps    <= n_steps;
        r_x        <= n_x;
        r_fwd_data <= n_fwd_data;
        r_oanc     <= n_oanc;
    end

endmodule

### tb/kth_ancestor_binary_lifting_test.sv
// Self-checking testbench for the binary-lifting ancestor table: link, remove and query requests.
module kth_ancestor_binary_lifting_test;
    import kab_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ENTRIES = NODES_DEF * LEVELS_DEF;
    localparam int RANDOM_REQUESTS = 1530;
    localparam int HOLD_CYCLES = 400;

    // Keeps its own copy of the ancestor table and the answers still owed by the block.
    class ancestor_table_model;
        t_entry rows [ENTRIES];
        logic [NODE_W-1:0] expected_ancestors [$];
        int unsigned failures;
        int unsigned answers;
        int unsigned links;
        int unsigned removes;
        int unsigned queries;

        function new();
            foreach (rows[i]) rows[i] = '0;
            failures = 0;
            answers = 0;
            links = 0;
            removes = 0;
            queries = 0;
        endfunction

        function t_entry read_entry(int unsigned v, int unsigned lvl);
            if (v >= NODES_DEF || lvl >= LEVELS_DEF) return '0;
            return rows[v * LEVELS_DEF + lvl];
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                                   logic [NODE_W-1:0] parent, logic [NODE_W-1:0] steps);
            t_entry below;
            t_entry up;
            t_entry hop;
            logic [NODE_W-1:0] at;
            int unsigned climb;
            bit lost;
            case (cmd)
                CMD_LINK: begin
                    links++;
                    if (node < NODES_DEF) begin
                        rows[node * LEVELS_DEF] = {1'b1, parent};
                        // Filling stops at the first level without an ancestor.
                        for (int i = 1; i < LEVELS_DEF; i++) begin
                            below = rows[node * LEVELS_DEF + i - 1];
                            up = '0;
                            if (below.vld) up = read_entry(below.node, i - 1);
                            rows[node * LEVELS_DEF + i] = up;
                            if (!up.vld) break;
                        end
                    end
                end
                CMD_REMOVE: begin
                    removes++;
                    if (node < NODES_DEF)
                        for (int i = 0; i < LEVELS_DEF; i++) rows[node * LEVELS_DEF + i] = '0;
                end
                CMD_QUERY: begin
                    queries++;
                    at = node;
                    climb = steps;
                    lost = (climb >> LEVELS_DEF) != 0;
                    for (int i = LEVELS_DEF - 1; i >= 0; i--) begin
                        if (!lost && climb[i]) begin
                            hop = read_entry(at, i);
                            if (hop.vld) at = hop.node;
                            else lost = 1'b1;
                        end
                    end
                    expected_ancestors.insert(expected_ancestors.size(), lost ? '0 : at);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [NODE_W-1:0] actual);
            logic [NODE_W-1:0] want;
            if (expected_ancestors.size() == 0) begin
                $display("%0t: result with no query waiting: expected none, actual %0d",
                         $time, actual);
                failures++;
                return;
            end
            want = expected_ancestors.pop_front();
            answers++;
            if (actual !== want) begin
                $display("%0t: ancestor mismatch: expected %0d, actual %0d", $time, want, actual);
                failures++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command;
    logic [NODE_W-1:0] i_node;
    logic [NODE_W-1:0] i_parent;
    logic [NODE_W-1:0] i_steps;
    logic              o_valid;
    logic              i_stall;
    logic [NODE_W-1:0] o_ancestor;

    ancestor_table_model lifting;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned requests_taken;

    kth_ancestor_binary_lifting #(
        .NODES (NODES_DEF),
        .LEVELS(LEVELS_DEF)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_node    (i_node),
        .i_parent  (i_parent),
        .i_steps   (i_steps),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_ancestor(o_ancestor)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("timeout with %0d answers still owed", lifting.expected_ancestors.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Called right after a rising edge; returns right after the edge that takes the request.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                                input logic [NODE_W-1:0] parent, input logic [NODE_W-1:0] steps);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_node    <= node;
        i_parent  <= parent;
        i_steps   <= steps;
        do @(posedge i_clk); while (o_stall);
        lifting.note_request(cmd, node, parent, steps);
        requests_taken <= requests_taken + 1;
    endtask

    // Result side: random stalls, plus one long hold-off early on so that requests back up.
    initial begin : result_sink
        int unsigned hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_used && requests_taken >= 60) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) lifting.check_result(o_ancestor);
    end

    initial begin : request_source
        logic [NODE_W-1:0] linked [$];
        logic [NODE_W-1:0] last_linked;
        logic [CMD_W-1:0] cmd;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] steps;
        int unsigned pick;
        int unsigned sent;
        int unsigned phase_idle [4];
        int unsigned phase_stall [4];

        lifting = new();
        phase_idle  = '{0, 83, 0, 31};
        phase_stall = '{0, 0, 83, 31};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_taken <= 0;
        last_linked = '0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_command <= CMD_LINK;
        i_node    <= '0;
        i_parent  <= '0;
        i_steps   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A short chain under the root, checked at steps 0, 1 and 3 and beyond its depth.
        send_request(CMD_LINK, 10'd1, 10'd0, 10'd0);
        send_request(CMD_LINK, 10'd2, 10'd1, 10'd0);
        send_request(CMD_LINK, 10'd3, 10'd2, 10'd0);
        send_request(CMD_QUERY, 10'd3, 10'd0, 10'd0);
        send_request(CMD_QUERY, 10'd3, 10'd0, 10'd1);
        send_request(CMD_QUERY, 10'd3, 10'd0, 10'd3);
        send_request(CMD_QUERY, 10'd3, 10'd0, 10'd4);
        // Self links fill every level from the level just written.
        send_request(CMD_LINK, 10'd5, 10'd5, 10'd0);
        send_request(CMD_QUERY, 10'd5, 10'd0, 10'd1023);
        send_request(CMD_LINK, 10'd1023, 10'd1023, 10'd1023);
        send_request(CMD_QUERY, 10'd1023, 10'd1023, 10'd1023);
        send_request(CMD_QUERY, 10'd1023, 10'd0, 10'd512);
        send_request(CMD_REMOVE, 10'd3, 10'd0, 10'd0);
        send_request(CMD_QUERY, 10'd3, 10'd0, 10'd1);
        send_request(CMD_QUERY, 10'd0, 10'd0, 10'd0);
        send_request(CMD_QUERY, 10'd0, 10'd0, 10'd1);
        // Giving the root a parent leaves the stale upper levels of node 1 in place.
        send_request(CMD_LINK, 10'd0, 10'd5, 10'd0);
        send_request(CMD_QUERY, 10'd0, 10'd0, 10'd512);
        send_request(CMD_QUERY, 10'd1, 10'd0, 10'd2);
        send_request(CMD_UNUSED, 10'd1023, 10'd1023, 10'd1023);
        send_request(CMD_REMOVE, 10'd1023, 10'd1023, 10'd1023);
        send_request(CMD_QUERY, 10'd1023, 10'd0, 10'd0);
        send_request(CMD_REMOVE, 10'd0, 10'd0, 10'd0);
        linked.insert(linked.size(), 10'd1);
        linked.insert(linked.size(), 10'd2);
        linked.insert(linked.size(), 10'd5);
        last_linked = 10'd2;

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = phase_idle[phase];
            recv_stall_pct = phase_stall[phase];
            sent = 0;
            while (sent < RANDOM_REQUESTS / 4) begin
                pick   = $urandom_range(0, 99);
                node   = NODE_W'($urandom);
                parent = NODE_W'($urandom);
                steps  = NODE_W'($urandom);
                if (pick < 45) begin
                    // Mostly grow chains from recent links so that queries climb far.
                    cmd = CMD_LINK;
                    pick = $urandom_range(0, 99);
                    if (pick < 60) parent = last_linked;
                    else if (pick < 90) parent = linked[$urandom_range(0, linked.size() - 1)];
                    if ($urandom_range(0, 99) < 20)
                        node = linked[$urandom_range(0, linked.size() - 1)];
                    linked.insert(linked.size(), node);
                    last_linked = node;
                end else if (pick < 53) begin
                    cmd = CMD_REMOVE;
                    if ($urandom_range(0, 99) < 70)
                        node = linked[$urandom_range(0, linked.size() - 1)];
                end else if (pick < 95) begin
                    cmd = CMD_QUERY;
                    if ($urandom_range(0, 99) < 75)
                        node = linked[$urandom_range(0, linked.size() - 1)];
                    pick = $urandom_range(0, 99);
                    if (pick < 40) steps = NODE_W'($urandom_range(0, 15));
                    else if (pick < 70) steps = NODE_W'(1) << $urandom_range(0, NODE_W - 1);
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_request(cmd, node, parent, steps);
                if (cmd != CMD_UNUSED) sent++;
            end
        end
        i_valid <= 1'b0;

        while (lifting.expected_ancestors.size() != 0) @(posedge i_clk);
        repeat (LEVELS_DEF + 4) @(posedge i_clk);

        $display("requests taken: %0d links, %0d removes, %0d queries, answers checked: %0d",
                 lifting.links, lifting.removes, lifting.queries, lifting.answers);
        $display("idle mixes: none, sender, receiver, both; one long result hold-off");
        if (lifting.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures", lifting.failures);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
